[src/svvt_pkg.sv]
// Shared types, constants and helpers for the sorted version vector table.
package svvt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int KEY_W     = 128;
    localparam int HALF_W    = 64;
    localparam int SIZE_W    = 5;
    localparam int CODE_W    = 3;
    localparam int COUNTER_W = 64;

    // Legal identifier sizes in bytes
    localparam logic [SIZE_W-1:0] ID_SIZE_MIN = 5'd17;
    localparam logic [SIZE_W-1:0] ID_SIZE_MAX = 5'd24;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_RAISED   = 3'd1,
        ST_KEPT     = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_SHIFT,
        S_DONE
    } state_t;

    // One table row
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [CODE_W-1:0]    code;
        logic [COUNTER_W-1:0] counter;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Request bundle from the engine to the table memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // Finished result from the engine
    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] count;
    } result_t;

    // Keep only the low (code + 1) bytes of the counter
    function automatic logic [COUNTER_W-1:0] mask_counter(
        input logic [COUNTER_W-1:0] value,
        input logic [CODE_W-1:0]    code
    );
        logic [CODE_W-1:0] drop_bytes;
        logic [5:0]        drop_bits;
        drop_bytes = 3'd7 - code;
        drop_bits  = {drop_bytes, 3'b000};
        return value & ({COUNTER_W{1'b1}} >> drop_bits);
    endfunction

endpackage

[src/sorted_version_vector_table_top.sv]
// Flow: a bad size goes straight to the result; an insert runs a binary search, each probe
// a read of the registered-read table RAM and a compare, then shifts the rows above the
// insert position up through the single write port and writes the new row.
// Throughput: one item at a time; a new beat is taken once the engine hands its result
// to the output register, which may still wait on out_ready.
// Reset: clears the entry count and control state; table rows are not cleared.
module sorted_version_vector_table_top
    import svvt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [HALF_W-1:0]    key_high,
    input  logic [HALF_W-1:0]    key_low,
    input  logic [SIZE_W-1:0]    id_size,
    input  logic [COUNTER_W-1:0] counter_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic [6:0]           entry_count
);

    ram_req_t ram_req;
    entry_t   ram_rdata;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [CNT_W-1:0] count_reg, count_next;

    svvt_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_high      (key_high),
        .key_low       (key_low),
        .id_size       (id_size),
        .counter_value (counter_value),
        .res_valid     (res_valid),
        .res           (res),
        .res_ready     (res_ready),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata)
    );

    svvt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            status_next    = res.status;
            count_next     = res.count;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = 7'(count_reg);

`ifndef SYNTHESIS
    // Engine is busy in the cycle after taking a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("engine took a beat while still busy");

    // Entry count never passes the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_reg <= CNT_W'(TABLE_DEPTH)))
        else $error("entry count above table depth");

    // A full refusal only comes from a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg == ST_FULL)) |-> (count_reg == CNT_W'(TABLE_DEPTH)))
        else $error("table full reported below depth");

    // An insert leaves at least one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg == ST_INSERTED)) |-> (count_reg != '0))
        else $error("insert reported with empty table");
`endif

endmodule

[src/svvt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module svvt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/svvt_engine.sv]
// Search, update and insert sequencer working on the table memory.
module svvt_engine
    import svvt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [HALF_W-1:0]    key_high,
    input  logic [HALF_W-1:0]    key_low,
    input  logic [SIZE_W-1:0]    id_size,
    input  logic [COUNTER_W-1:0] counter_value,
    output logic                 res_valid,
    output result_t              res,
    input  logic                 res_ready,
    output ram_req_t             ram_req,
    input  entry_t               ram_rdata
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     used_reg, used_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [COUNTER_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [ADDR_W-1:0]    mid_reg, mid_next;
    logic [ADDR_W-1:0]    shift_rd_reg, shift_rd_next;
    logic [CNT_W-1:0]     rd_left_reg, rd_left_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]    wr_addr_reg, wr_addr_next;
    status_t              status_reg, status_next;

    logic             size_ok;
    logic [CODE_W-1:0] in_code;
    logic [CNT_W:0]   mid_sum;
    logic [ADDR_W-1:0] mid;
    logic             table_full;
    logic             key_less;
    logic             key_eq;
    logic             shift_done;
    entry_t           new_entry;

    // Input decode
    assign size_ok = (id_size >= ID_SIZE_MIN) && (id_size <= ID_SIZE_MAX);
    assign in_code = CODE_W'(id_size - ID_SIZE_MIN);

    // Binary search midpoint and table status
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[ADDR_W:1];
    assign table_full = (used_reg == CNT_W'(TABLE_DEPTH));

    // Key compare against the row read back
    assign key_less   = ram_rdata.key < key_reg;
    assign key_eq     = ram_rdata.key == key_reg;
    assign shift_done = (rd_left_reg == '0) && !wr_pend_reg;

    assign new_entry.key     = key_reg;
    assign new_entry.code    = code_reg;
    assign new_entry.counter = cnt_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = size_ok ? S_SEARCH : S_DONE;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    state_next = table_full ? S_DONE : S_SHIFT;
                end
                else
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                state_next = key_eq ? S_DONE : S_SEARCH;
            end
            S_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs, memory requests and datapath updates
    always_comb
    begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        ram_req       = '0;
        used_next     = used_reg;
        key_next      = key_reg;
        code_next     = code_reg;
        cnt_next      = cnt_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        shift_rd_next = shift_rd_reg;
        rd_left_next  = rd_left_reg;
        wr_pend_next  = wr_pend_reg;
        wr_addr_next  = wr_addr_reg;
        status_next   = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next    = {key_high, key_low};
                    code_next   = in_code;
                    cnt_next    = mask_counter(counter_value, in_code);
                    lo_next     = '0;
                    hi_next     = used_reg;
                    status_next = ST_MISMATCH;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    // lo_reg is the insert position
                    if (table_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        shift_rd_next = ADDR_W'(used_reg - CNT_W'(1));
                        rd_left_next  = used_reg - lo_reg;
                        wr_pend_next  = 1'b0;
                    end
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = mid;
                    mid_next      = mid;
                end
            end
            S_COMPARE:
            begin
                if (key_eq)
                begin
                    if (ram_rdata.code != code_reg)
                    begin
                        status_next = ST_MISMATCH;
                    end
                    else if (cnt_reg > ram_rdata.counter)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = mid_reg;
                        ram_req.wdata = new_entry;
                        status_next   = ST_RAISED;
                    end
                    else
                    begin
                        status_next = ST_KEPT;
                    end
                end
                else if (key_less)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                end
            end
            S_SHIFT:
            begin
                // Move rows up one place, top down, one per cycle
                if (rd_left_reg != '0)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = shift_rd_reg;
                    shift_rd_next = shift_rd_reg - ADDR_W'(1);
                    rd_left_next  = rd_left_reg - CNT_W'(1);
                    wr_pend_next  = 1'b1;
                    wr_addr_next  = shift_rd_reg + ADDR_W'(1);
                end
                else
                begin
                    wr_pend_next = 1'b0;
                end
                if (wr_pend_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = wr_addr_reg;
                    ram_req.wdata = ram_rdata;
                end
                else if (shift_done)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = lo_reg[ADDR_W-1:0];
                    ram_req.wdata = new_entry;
                    used_next     = used_reg + CNT_W'(1);
                    status_next   = ST_INSERTED;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res.status = status_reg;
    assign res.count  = used_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            wr_pend_reg <= 1'b0;
            rd_left_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            wr_pend_reg <= wr_pend_next;
            rd_left_reg <= rd_left_next;
        end
    end

    // Item payload and search pointers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        code_reg     <= code_next;
        cnt_reg      <= cnt_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        shift_rd_reg <= shift_rd_next;
        wr_addr_reg  <= wr_addr_next;
        status_reg   <= status_next;
    end

endmodule
